@@ src/dtpw_pkg.sv @@
package dtpw_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int DEPTH_ONE_DEF  = 16384;

    localparam int KIND_W     = 2;
    localparam int COORD_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int COLOUR_W   = 32;
    localparam int DEPTH_W    = 8;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [KIND_W-1:0]     t_kind;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_PIXEL = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    localparam t_status STATUS_WRITTEN  = 2'd0;
    localparam t_status STATUS_OUTSIDE  = 2'd1;
    localparam t_status STATUS_OCCLUDED = 2'd2;
    localparam t_status STATUS_DONE     = 2'd3;

    localparam t_cfg_idx CFG_FRAME_W = 2'd0;
    localparam t_cfg_idx CFG_FRAME_H = 2'd1;

    localparam t_cfg_data SCREEN_SIZE_RESET = 10'd512;

    localparam logic [COLOUR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;
    localparam logic [DEPTH_W-1:0]  DEPTH_FAR    = 8'hFF;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic signed [COORD_W-1:0] depth_in;
        logic [CHAN_W-1:0]         red_in;
        logic [CHAN_W-1:0]         green_in;
        logic [CHAN_W-1:0]         blue_in;
        logic [CHAN_W-1:0]         alpha_in;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [COLOUR_W-1:0] read_colour;
        logic [DEPTH_W-1:0]  read_depth;
        logic [CNT_W-1:0]    outside_count;
        logic [CNT_W-1:0]    occluded_count;
    } t_out_item;

    // bits of (z + one) * 255, with z + one in [0, 2 * one]
    function automatic int num_width(input int depth_one);
        return $clog2(2 * depth_one + 1) + DEPTH_W;
    endfunction

endpackage

@@ src/dtpw_if.sv @@
interface dtpw_in_if;
    logic                valid;
    logic                ready;
    dtpw_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtpw_out_if;
    logic                valid;
    logic                ready;
    dtpw_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtpw_cfg_if;
    logic                valid;
    logic                ready;
    dtpw_pkg::t_cfg_idx  index;
    dtpw_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/dtpw_zquant.sv @@
module dtpw_zquant #(
    parameter int DEPTH_ONE = dtpw_pkg::DEPTH_ONE_DEF
) (
    input  logic                                        i_clk,
    input  logic signed [dtpw_pkg::COORD_W-1:0]         i_depth,
    output logic [dtpw_pkg::num_width(DEPTH_ONE)-1:0]   o_num,
    output logic [dtpw_pkg::DEPTH_W-1:0]                o_q
);

    localparam int NUM_W   = dtpw_pkg::num_width(DEPTH_ONE);
    localparam int DEN     = 2 * DEPTH_ONE;
    localparam int SUM_W   = $clog2(DEN + 1);
    localparam int SHIFT   = NUM_W;
    localparam int RECIP   = (2 ** SHIFT) / DEN;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int DW      = dtpw_pkg::DEPTH_W;
    localparam logic signed [dtpw_pkg::COORD_W:0] ONE_S = (dtpw_pkg::COORD_W + 1)'(DEPTH_ONE);

    logic signed [dtpw_pkg::COORD_W:0] sum_s;
    logic [PROD_W-1:0]                 prod;
    logic [NUM_W-1:0]                  rem;

    logic [NUM_W-1:0] r_num1;
    logic [NUM_W-1:0] r_num2;
    logic [DW-1:0]    r_q0;
    logic [NUM_W-1:0] r_num3;
    logic [DW-1:0]    r_q;

    // shift to [0, 2*one], scale by 255
    assign sum_s = {i_depth[dtpw_pkg::COORD_W-1], i_depth} + ONE_S;

    // quotient estimate by reciprocal, never above the true one and at most one below
    assign prod = PROD_W'(r_num1) * PROD_W'(RECIP);

    assign rem = r_num2 - NUM_W'(r_q0) * NUM_W'(DEN);

    always_ff @(posedge i_clk) begin
        r_num1 <= NUM_W'(sum_s[SUM_W-1:0]) * NUM_W'(255);
        r_num2 <= r_num1;
        r_q0   <= DW'(prod >> SHIFT);
        r_num3 <= r_num2;
        r_q    <= r_q0 + {{(DW-1){1'b0}}, (rem >= NUM_W'(DEN))};
    end

    assign o_num = r_num3;
    assign o_q   = r_q;

endmodule

@@ src/depth_tested_pixel_write.sv @@
// channel   dir  handshake          payload
// i_in      in   valid / ready      kind, pixel_x, pixel_y, depth_in, red/green/blue/alpha_in
// o_out     out  valid / ready      status, read_colour, read_depth, outside/occluded_count
// i_cfg     in   valid / ready      index (0 active width, 1 active height), data
//
// pixel write, read and ignored kind: S_ADDR, S_CALC1, S_CALC2, S_FIN; no new item is
// taken meanwhile, while the store read and the three-stage depth quantizer ahead of the
// write-back complete. clear: one store entry written per cycle, MAX_WIDTH*MAX_HEIGHT in all.
// after reset the same sweep runs with i_in.ready low;
// configuration writes are taken at any time.
// a finished result waits in the output register; the next item is accepted meanwhile
// and holds in its last cycle until the register frees.
module depth_tested_pixel_write #(
    parameter int MAX_WIDTH  = dtpw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpw_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_ONE  = dtpw_pkg::DEPTH_ONE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtpw_in_if.sink     i_in,
    dtpw_out_if.source  o_out,
    dtpw_cfg_if.sink    i_cfg
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int NUM_W      = dtpw_pkg::num_width(DEPTH_ONE);
    localparam int DEN        = 2 * DEPTH_ONE;
    localparam int DW         = dtpw_pkg::DEPTH_W;
    localparam int CW         = dtpw_pkg::COLOUR_W;
    localparam int ENTRY_W    = DW + CW;
    localparam int XW         = dtpw_pkg::COORD_W;
    localparam int CNT_W      = dtpw_pkg::CNT_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam logic [XW-1:0]     MAX_W_C   = XW'(MAX_WIDTH);
    localparam logic [XW-1:0]     MAX_H_C   = XW'(MAX_HEIGHT);
    localparam logic signed [XW:0] ZLIM     = (XW + 1)'(DEPTH_ONE);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CALC1 = 3'd3;
    localparam logic [2:0] S_CALC2 = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [ENTRY_W-1:0] r_mem [STORE_SIZE];

    logic [2:0]                r_state,    n_state;
    logic [ADDR_W-1:0]         r_clr_ptr,  n_clr_ptr;
    logic                      r_clr_item, n_clr_item;
    logic [CNT_W-1:0]          r_outside,  n_outside;
    logic [CNT_W-1:0]          r_occluded, n_occluded;
    logic                      r_out_valid, n_out_valid;
    dtpw_pkg::t_out_item       r_out,      n_out;
    dtpw_pkg::t_cfg_data       r_width;
    dtpw_pkg::t_cfg_data       r_height;

    dtpw_pkg::t_in_item        r_item;
    logic                      r_on_screen;
    logic                      r_in_depth;
    logic [ADDR_W-1:0]         r_addr;
    logic [ENTRY_W-1:0]        r_rd;
    logic [NUM_W-1:0]          r_sprod;

    logic                      in_acc;
    logic                      out_free;
    logic [XW-1:0]             w_eff;
    logic [XW-1:0]             h_eff;
    logic                      x_ok;
    logic                      y_ok;
    logic                      on_screen;
    logic signed [XW:0]        z_s;
    logic                      in_depth;
    logic [ADDR_W-1:0]         addr_c;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ENTRY_W-1:0]        wr_data;
    logic [NUM_W-1:0]          zq_num;
    logic [DW-1:0]             zq_q;

    dtpw_zquant #(
        .DEPTH_ONE (DEPTH_ONE)
    ) u_zquant (
        .i_clk   (i_clk),
        .i_depth (r_item.depth_in),
        .o_num   (zq_num),
        .o_q     (zq_q)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // bounds test against the active size, clamped to the store
    assign w_eff = (XW'(r_width)  > MAX_W_C) ? MAX_W_C : XW'(r_width);
    assign h_eff = (XW'(r_height) > MAX_H_C) ? MAX_H_C : XW'(r_height);
    assign x_ok  = !r_item.pixel_x[XW-1] && ($unsigned(r_item.pixel_x) < w_eff);
    assign y_ok  = !r_item.pixel_y[XW-1] && ($unsigned(r_item.pixel_y) < h_eff);
    assign on_screen = x_ok && y_ok;

    assign z_s      = {r_item.depth_in[XW-1], r_item.depth_in};
    assign in_depth = (z_s >= -ZLIM) && (z_s <= ZLIM);

    assign addr_c = on_screen ?
        ADDR_W'(32'(r_item.pixel_y[XW-2:0]) * 32'(MAX_WIDTH) + 32'(r_item.pixel_x[XW-2:0])) :
        '0;

    always_comb begin
        n_state     = r_state;
        n_clr_ptr   = r_clr_ptr;
        n_clr_item  = r_clr_item;
        n_outside   = r_outside;
        n_occluded  = r_occluded;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = {zq_q, r_item.red_in, r_item.green_in, r_item.blue_in, r_item.alpha_in};
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_ptr;
                wr_data = {dtpw_pkg::DEPTH_FAR, dtpw_pkg::OPAQUE_BLACK};
                if (r_clr_ptr == LAST_ADDR) begin
                    n_clr_ptr = '0;
                    n_state   = r_clr_item ? S_FIN : S_IDLE;
                end else begin
                    n_clr_ptr = r_clr_ptr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.kind == dtpw_pkg::KIND_CLEAR) begin
                        n_state    = S_CLEAR;
                        n_clr_item = 1'b1;
                        n_clr_ptr  = '0;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_CALC1;
            end
            S_CALC1: begin
                n_state = S_CALC2;
            end
            S_CALC2: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state           = S_IDLE;
                    n_clr_item        = 1'b0;
                    n_out_valid       = 1'b1;
                    n_out.status      = dtpw_pkg::STATUS_DONE;
                    n_out.read_colour = '0;
                    n_out.read_depth  = '0;
                    case (r_item.kind)
                        dtpw_pkg::KIND_CLEAR: begin
                            n_outside  = '0;
                            n_occluded = '0;
                        end
                        dtpw_pkg::KIND_PIXEL: begin
                            if (!r_on_screen || !r_in_depth) begin
                                n_outside    = (&r_outside) ? r_outside : r_outside + CNT_W'(1);
                                n_out.status = dtpw_pkg::STATUS_OUTSIDE;
                            end else if (r_sprod < zq_num) begin
                                n_occluded   = (&r_occluded) ? r_occluded :
                                               r_occluded + CNT_W'(1);
                                n_out.status = dtpw_pkg::STATUS_OCCLUDED;
                            end else begin
                                wr_en        = 1'b1;
                                n_out.status = dtpw_pkg::STATUS_WRITTEN;
                            end
                        end
                        dtpw_pkg::KIND_READ: begin
                            if (r_on_screen) begin
                                n_out.read_colour = r_rd[CW-1:0];
                                n_out.read_depth  = r_rd[ENTRY_W-1 -: DW];
                            end else begin
                                n_out.status = dtpw_pkg::STATUS_OUTSIDE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.outside_count  = n_outside;
                    n_out.occluded_count = n_occluded;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_ptr   <= '0;
            r_clr_item  <= 1'b0;
            r_outside   <= '0;
            r_occluded  <= '0;
            r_out_valid <= 1'b0;
            r_width     <= dtpw_pkg::SCREEN_SIZE_RESET;
            r_height    <= dtpw_pkg::SCREEN_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_ptr   <= n_clr_ptr;
            r_clr_item  <= n_clr_item;
            r_outside   <= n_outside;
            r_occluded  <= n_occluded;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    dtpw_pkg::CFG_FRAME_W: r_width  <= i_cfg.data;
                    dtpw_pkg::CFG_FRAME_H: r_height <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_item <= i_in.data;
        end
        if (r_state == S_ADDR) begin
            r_on_screen <= on_screen;
            r_in_depth  <= in_depth;
            r_addr      <= addr_c;
        end
        if (r_state == S_CALC1) begin
            r_sprod <= NUM_W'(r_rd[ENTRY_W-1 -: DW]) * NUM_W'(DEN);
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_state == S_ADDR) begin
            r_rd <= r_mem[addr_c];
        end
    end

endmodule

@@ src/dtpw_checker.sv @@
module dtpw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input dtpw_pkg::t_out_item i_out_data
);

    // one item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while another is in flight");

    // the store is swept after reset before any item is taken; this checks ready is low right after reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // read fields are zero on any result whose status is not done (a write or a reject)
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != dtpw_pkg::STATUS_DONE)
        |-> (i_out_data.read_colour == '0) && (i_out_data.read_depth == '0))
        else $error("read fields nonzero on a write or reject result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind depth_tested_pixel_write dtpw_checker u_dtpw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
